### rtl/upscale_2x_box_smooth_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the 2x upscaler
// clocked implication checks, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef UPSCALE_2X_BOX_SMOOTH_ASSERT_SVH
`define UPSCALE_2X_BOX_SMOOTH_ASSERT_SVH

// same-cycle implication
`define UBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ubs_pkg.sv
// ----------------------------------------------------------------------------
// ubs_pkg
// shared widths, register codes, pixel types and the smoothing arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

package ubs_pkg;

   localparam int CH_W         = 8;
   localparam int PIXEL_W      = 3 * CH_W;
   localparam int ROW_W        = 13;
   localparam int COL_W        = 12;
   localparam int SRC_WIDTH_W  = 12;
   localparam int SRC_HEIGHT_W = 13;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_BIT  = 2;

   localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = 12'd640;
   localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RST = 13'd480;

   // 3x3 candidate grid around each source pixel
   localparam int CAND_N = 9;
   localparam int TAP_N  = 3;

   localparam logic [1:0] TAP_LO  = 2'd0;
   localparam logic [1:0] TAP_MID = 2'd1;
   localparam logic [1:0] TAP_HI  = 2'd2;

   // taps that may copy (border) and that may average (interior)
   localparam logic [TAP_N-1:0] TAP_COPY  = 3'b110;
   localparam logic [TAP_N-1:0] TAP_INNER = 3'b011;

   // nine-sample sum and divide by nine as multiply by reciprocal
   localparam int               SUM_W      = 12;
   localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
   localparam int               DIV9_SHIFT = 15;

   typedef enum logic [0:0] {
      CSR_SRC_WIDTH  = 1'b0,
      CSR_SRC_HEIGHT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [CH_W-1:0] ch2;
      logic [CH_W-1:0] ch1;
      logic [CH_W-1:0] ch0;
   } pixel_type;

   typedef struct packed {
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
   } edge_flags_type;

   // which of the nine candidates a source pixel completes
   function automatic logic [CAND_N-1:0] cand_mask(input edge_flags_type f);
      logic [TAP_N-1:0]  rin;
      logic [TAP_N-1:0]  rb;
      logic [TAP_N-1:0]  cin;
      logic [TAP_N-1:0]  cb;
      logic [CAND_N-1:0] m;
      rin = {1'b1, 1'b1, !f.first_row};
      rb  = {f.last_row, f.first_row, 1'b0};
      cin = {1'b1, 1'b1, !f.first_col};
      cb  = {f.last_col, f.first_col, 1'b0};
      m   = '0;
      for (int di = 0; di < TAP_N; di++) begin
         for (int dj = 0; dj < TAP_N; dj++) begin
            m[di * TAP_N + dj] = rin[di] && cin[dj] &&
               ((rb[di] || cb[dj]) ? (TAP_COPY[di] && TAP_COPY[dj])
                                   : (TAP_INNER[di] && TAP_INNER[dj]));
         end
      end
      return m;
   endfunction

   function automatic logic [SUM_W-1:0] wsum(
      input logic [CH_W-1:0] a,
      input logic [CH_W-1:0] b,
      input logic [CH_W-1:0] c,
      input logic [CH_W-1:0] d,
      input logic [1:0]      sa,
      input logic [1:0]      sb,
      input logic [1:0]      sc,
      input logic [1:0]      sd
   );
      return (SUM_W'(a) << sa) + (SUM_W'(b) << sb) + (SUM_W'(c) << sc) + (SUM_W'(d) << sd);
   endfunction

   // exact floor of s / 9 for s up to 9 * 255
   function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
      logic [2*SUM_W-1:0] prod;
      prod = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_MUL);
      return prod[DIV9_SHIFT +: CH_W];
   endfunction

   function automatic pixel_type mean9(
      input pixel_type  ul,
      input pixel_type  ur,
      input pixel_type  ll,
      input pixel_type  lr,
      input logic [1:0] s_ul,
      input logic [1:0] s_ur,
      input logic [1:0] s_ll,
      input logic [1:0] s_lr
   );
      pixel_type m;
      m.ch0 = div9(wsum(ul.ch0, ur.ch0, ll.ch0, lr.ch0, s_ul, s_ur, s_ll, s_lr));
      m.ch1 = div9(wsum(ul.ch1, ur.ch1, ll.ch1, lr.ch1, s_ul, s_ur, s_ll, s_lr));
      m.ch2 = div9(wsum(ul.ch2, ur.ch2, ll.ch2, lr.ch2, s_ul, s_ur, s_ll, s_lr));
      return m;
   endfunction

endpackage

`default_nettype wire

### rtl/ubs_req_if.sv
// ----------------------------------------------------------------------------
// ubs_req_if
// source pixel channel, valid/ready with three 8-bit channels
// ----------------------------------------------------------------------------
`default_nettype none

interface ubs_req_if import ubs_pkg::*; ();

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch0_in;
   logic [CH_W-1:0] ch1_in;
   logic [CH_W-1:0] ch2_in;

   modport source (output valid, ch0_in, ch1_in, ch2_in, input ready);
   modport sink   (input valid, ch0_in, ch1_in, ch2_in, output ready);

endinterface

`default_nettype wire

### rtl/ubs_rsp_if.sv
// ----------------------------------------------------------------------------
// ubs_rsp_if
// output pixel channel, valid/ready with coordinates and channels
// ----------------------------------------------------------------------------
`default_nettype none

interface ubs_rsp_if import ubs_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;
   logic [CH_W-1:0]  ch0_out;
   logic [CH_W-1:0]  ch1_out;
   logic [CH_W-1:0]  ch2_out;
   logic             run_last;

   modport source (output valid, out_row, out_col, ch0_out, ch1_out, ch2_out, run_last,
                   input ready);
   modport sink   (input valid, out_row, out_col, ch0_out, ch1_out, ch2_out, run_last,
                   output ready);

endinterface

`default_nettype wire

### rtl/ubs_ram.sv
// ----------------------------------------------------------------------------
// ubs_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ubs_ram #(
   parameter  int WIDTH  = 24,
   parameter  int DEPTH  = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write at one address return the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/upscale_2x_box_smooth.sv
// ----------------------------------------------------------------------------
// upscale_2x_box_smooth
// 2x nearest-neighbour upscale followed by a 3x3 truncated mean filter
//
// req takes source pixels in raster order, one word per pixel. rsp gives the
// output pixels of the double-size image with their row and column; border
// pixels copy their source pixel, the rest are the mean of nine samples.
// each source word yields 2 to 7 output words, about 4 inside a frame, and
// run_last marks the final one of that group.
// a source word passes through the work register and then the single output
// register, which holds one result at a time.
// the next source word is taken in the cycle the last result of the current
// one moves into the output register, so words follow with no gap.
// if the receiver stalls, one result waits in the output register and the
// rest wait in the work register; nothing is dropped.
// reset returns the counters to the first pixel of a frame and the size
// registers to 640 x 480; the row memory is not cleared. csr: source width at
// byte 0, source height at byte 4; unenforced, the user writes only while idle
// ----------------------------------------------------------------------------
`default_nettype none

`include "upscale_2x_box_smooth_assert.svh"

module upscale_2x_box_smooth import ubs_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ubs_req_if.sink                    req,
   ubs_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // counter widths: index holds a position, count holds the size itself
   localparam int COL_IDX_W = $clog2(MAX_WIDTH);
   localparam int COL_CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_IDX_W = $clog2(MAX_HEIGHT);
   localparam int ROW_CNT_W = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_OUT_W = (ROW_IDX_W + 1 > ROW_W) ? ROW_IDX_W + 1 : ROW_W;
   localparam int COL_OUT_W = (COL_IDX_W + 1 > COL_W) ? COL_IDX_W + 1 : COL_W;

   // ---------------------------------------------------------------- csr

   logic [SRC_WIDTH_W-1:0]  src_width_ff;
   logic [SRC_HEIGHT_W-1:0] src_height_ff;
   logic                    csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_WIDTH_RST;
         src_height_ff <= SRC_HEIGHT_RST;
      end else if (csr_wr) begin
         case (csr_idx_type'(csr_paddr[CSR_IDX_BIT]))
            CSR_SRC_WIDTH: begin
               src_width_ff <= csr_pwdata[SRC_WIDTH_W-1:0];
            end
            CSR_SRC_HEIGHT: begin
               src_height_ff <= csr_pwdata[SRC_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx_type'(csr_paddr[CSR_IDX_BIT]))
         CSR_SRC_WIDTH:  csr_prdata = CSR_DATA_W'(src_width_ff);
         CSR_SRC_HEIGHT: csr_prdata = CSR_DATA_W'(src_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- sizes

   // zero is taken as one, anything above the maximum as the maximum
   logic [31:0]          w_wide;
   logic [31:0]          h_wide;
   logic [COL_CNT_W-1:0] w_eff;
   logic [ROW_CNT_W-1:0] h_eff;

   always_comb begin
      if (src_width_ff == '0) begin
         w_wide = 32'd1;
      end else if (32'(src_width_ff) > 32'(MAX_WIDTH)) begin
         w_wide = 32'(MAX_WIDTH);
      end else begin
         w_wide = 32'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         h_wide = 32'd1;
      end else if (32'(src_height_ff) > 32'(MAX_HEIGHT)) begin
         h_wide = 32'(MAX_HEIGHT);
      end else begin
         h_wide = 32'(src_height_ff);
      end
   end

   assign w_eff = w_wide[COL_CNT_W-1:0];
   assign h_eff = h_wide[ROW_CNT_W-1:0];

   // ---------------------------------------------------------------- position

   logic [COL_IDX_W-1:0] col_ff;
   logic [COL_IDX_W-1:0] col_in;
   logic [ROW_IDX_W-1:0] row_ff;
   logic [ROW_IDX_W-1:0] row_in;
   logic [COL_IDX_W-1:0] c_eff;
   logic [ROW_IDX_W-1:0] r_eff;
   logic [COL_CNT_W-1:0] c_next_full;
   logic [ROW_CNT_W-1:0] r_next_full;
   logic                 wrap_col;
   logic                 wrap_row;
   edge_flags_type       new_edge;

   // a count left beyond a shrunk size restarts at zero
   assign c_eff = (COL_CNT_W'(col_ff) >= w_eff) ? '0 : col_ff;
   assign r_eff = (ROW_CNT_W'(row_ff) >= h_eff) ? '0 : row_ff;

   assign c_next_full = COL_CNT_W'(c_eff) + COL_CNT_W'(1);
   assign r_next_full = ROW_CNT_W'(r_eff) + ROW_CNT_W'(1);
   assign wrap_col    = c_next_full >= w_eff;
   assign wrap_row    = r_next_full >= h_eff;

   always_comb begin
      if (wrap_col) begin
         col_in = '0;
         row_in = wrap_row ? '0 : r_next_full[ROW_IDX_W-1:0];
      end else begin
         col_in = c_next_full[COL_IDX_W-1:0];
         row_in = r_eff;
      end
   end

   assign new_edge.first_row = (r_eff == '0);
   assign new_edge.last_row  = (ROW_CNT_W'(r_eff) == h_eff - ROW_CNT_W'(1));
   assign new_edge.first_col = (c_eff == '0);
   assign new_edge.last_col  = (COL_CNT_W'(c_eff) == w_eff - COL_CNT_W'(1));

   // ---------------------------------------------------------------- handshake

   logic [CAND_N-1:0] job_mask_ff;
   logic [CAND_N-1:0] job_mask_in;
   logic [CAND_N-1:0] mask_rest;
   logic              job_active;
   logic              out_load;
   logic              job_last;
   logic              accept;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   // the work register is busy while candidates remain
   assign job_active = |job_mask_ff;
   assign out_load   = job_active && (!rsp_valid_ff || rsp.ready);
   assign job_last   = out_load && (mask_rest == '0);

   // the next word enters as the last result of this one leaves
   assign req.ready  = !job_active || job_last;
   assign accept     = req.valid && req.ready;

   always_comb begin
      if (accept) begin
         job_mask_in = cand_mask(new_edge);
      end else if (out_load) begin
         job_mask_in = mask_rest;
      end else begin
         job_mask_in = job_mask_ff;
      end
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   // ---------------------------------------------------------------- row memory

   pixel_type req_pix;
   pixel_type up_pix;
   logic [PIXEL_W-1:0] ram_rd_data;

   assign req_pix.ch0 = req.ch0_in;
   assign req_pix.ch1 = req.ch1_in;
   assign req_pix.ch2 = req.ch2_in;

   // pixel above is read while the new pixel overwrites it; read data holds
   // until the next accepted word, so it stays aligned with the work register
   ubs_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (c_eff),
      .wr_data (req_pix),
      .rd_en   (accept),
      .rd_addr (c_eff),
      .rd_data (ram_rd_data)
   );

   assign up_pix = pixel_type'(ram_rd_data);

   // ---------------------------------------------------------------- work register

   pixel_type            left_ff;
   pixel_type            job_cur_ff;
   pixel_type            job_left_ff;
   pixel_type            job_upleft_ff;
   logic [ROW_IDX_W-1:0] job_row_ff;
   logic [COL_IDX_W-1:0] job_col_ff;
   edge_flags_type       job_edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
      end else begin
         job_mask_ff  <= job_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            left_ff <= req_pix;
         end
      end
   end

   // upper-left is the previous word's pixel above, still on the read port
   always_ff @(posedge clock) begin
      if (accept) begin
         job_cur_ff    <= req_pix;
         job_left_ff   <= left_ff;
         job_upleft_ff <= up_pix;
         job_row_ff    <= r_eff;
         job_col_ff    <= c_eff;
         job_edge_ff   <= new_edge;
      end
   end

   // ---------------------------------------------------------------- result select

   logic [1:0]          sel_di;
   logic [1:0]          sel_dj;
   logic [CAND_N-1:0]   sel_hot;
   logic                found;
   logic                is_border;
   logic                up_heavy;
   logic                left_heavy;
   logic [1:0]          s_ul;
   logic [1:0]          s_ur;
   logic [1:0]          s_ll;
   logic [1:0]          s_lr;
   pixel_type           mean_pix;
   pixel_type           out_pix;
   logic [ROW_OUT_W-1:0] row_full;
   logic [COL_OUT_W-1:0] col_full;

   // lowest pending candidate first keeps raster order
   always_comb begin
      found   = 1'b0;
      sel_di  = TAP_LO;
      sel_dj  = TAP_LO;
      sel_hot = '0;
      for (int di = 0; di < TAP_N; di++) begin
         for (int dj = 0; dj < TAP_N; dj++) begin
            if (!found && job_mask_ff[di * TAP_N + dj]) begin
               found                  = 1'b1;
               sel_di                 = 2'(di);
               sel_dj                 = 2'(dj);
               sel_hot[di * TAP_N + dj] = 1'b1;
            end
         end
      end
   end

   assign mask_rest = job_mask_ff & ~sel_hot;

   // first or last output row or column
   assign is_border = (sel_di == TAP_MID && job_edge_ff.first_row) ||
                      (sel_di == TAP_HI  && job_edge_ff.last_row)  ||
                      (sel_dj == TAP_MID && job_edge_ff.first_col) ||
                      (sel_dj == TAP_HI  && job_edge_ff.last_col);

   // odd output row leans on the row above, odd column on the left one
   assign up_heavy   = (sel_di == TAP_LO);
   assign left_heavy = (sel_dj == TAP_LO);
   assign s_ul = {1'b0, up_heavy}  + {1'b0, left_heavy};
   assign s_ur = {1'b0, up_heavy}  + {1'b0, !left_heavy};
   assign s_ll = {1'b0, !up_heavy} + {1'b0, left_heavy};
   assign s_lr = {1'b0, !up_heavy} + {1'b0, !left_heavy};

   assign mean_pix = mean9(job_upleft_ff, up_pix, job_left_ff, job_cur_ff,
                           s_ul, s_ur, s_ll, s_lr);
   assign out_pix  = is_border ? job_cur_ff : mean_pix;

   // output coordinate is twice the source one, less one, plus the tap
   assign row_full = ROW_OUT_W'({job_row_ff, 1'b0}) + ROW_OUT_W'(sel_di) - ROW_OUT_W'(1);
   assign col_full = COL_OUT_W'({job_col_ff, 1'b0}) + COL_OUT_W'(sel_dj) - COL_OUT_W'(1);

   // ---------------------------------------------------------------- output register

   logic [ROW_W-1:0] rsp_row_ff;
   logic [COL_W-1:0] rsp_col_ff;
   pixel_type        rsp_pix_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_row_ff  <= row_full[ROW_W-1:0];
         rsp_col_ff  <= col_full[COL_W-1:0];
         rsp_pix_ff  <= out_pix;
         rsp_last_ff <= (mask_rest == '0);
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_row  = rsp_row_ff;
   assign rsp.out_col  = rsp_col_ff;
   assign rsp.ch0_out  = rsp_pix_ff.ch0;
   assign rsp.ch1_out  = rsp_pix_ff.ch1;
   assign rsp.ch2_out  = rsp_pix_ff.ch2;
   assign rsp.run_last = rsp_last_ff;

   // ---------------------------------------------------------------- checks

   // every source word leaves at least one candidate pending
   `UBS_ASSERT_NXT(a_accept_fills_job, clock, reset, accept, job_active,
      "accepted word left no pending result")

   // a source word never completes more than seven outputs
   `UBS_ASSERT_IMP(a_job_at_most_seven, clock, reset, 1'b1,
      $countones(job_mask_ff) <= 7, "more than seven results pending")

   // pending work reaches an empty output register in the next cycle
   `UBS_ASSERT_NXT(a_job_drains, clock, reset, job_active && !rsp_valid_ff, rsp_valid_ff,
      "pending result not moved to output register")

   // a stalled receiver freezes the work in hand
   `UBS_ASSERT_NXT(a_stall_holds_job, clock, reset,
      job_active && rsp_valid_ff && !rsp.ready, $stable(job_mask_ff),
      "pending results changed while receiver stalled")

endmodule

`default_nettype wire
